### sv/oqd_pkg.sv
// ----------------------------------------------------------------------------
// oqd_pkg
// Shared types and constants for the ordered tag queue with delete.
// ----------------------------------------------------------------------------
package oqd_pkg;

    localparam int DEPTH = 16;
    localparam int TAG_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Encoding of the action field on the input port
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_PUSH   = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;
    localparam logic [1:0] ACT_DELETE = 2'd3;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_PUSH,
        OP_POP,
        OP_DELETE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [TAG_W-1:0] tag;
    } t_cmd;

endpackage

### sv/oqd_front.sv
// ----------------------------------------------------------------------------
// oqd_front
// Accepts commands, decodes the action code and holds them in a two-entry
// queue that decouples the input channel from the cell array.
// ----------------------------------------------------------------------------
module oqd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_item,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output oqd_pkg::t_cmd      o_cmd
);
    import oqd_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    t_cmd       dec_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        dec_cmd.tag = i_item[TAG_W-1:0];
        unique case (i_action)
            ACT_APPEND: dec_cmd.op = OP_APPEND;
            ACT_PUSH:   dec_cmd.op = OP_PUSH;
            ACT_POP:    dec_cmd.op = OP_POP;
            ACT_DELETE: dec_cmd.op = OP_DELETE;
            default:    dec_cmd.op = OP_DELETE;
        endcase
    end

    assign o_ready     = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### sv/oqd_back.sv
// ----------------------------------------------------------------------------
// oqd_back
// Row of tag cells with parallel compare and shift. Executes one command per
// cycle unless the output stalls, and registers its result for the output.
// ----------------------------------------------------------------------------
module oqd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  oqd_pkg::t_cmd             i_cmd,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [31:0]               o_popped_item,
    output logic [oqd_pkg::CNT_W-1:0] o_count
);
    import oqd_pkg::*;

    logic [TAG_W-1:0] r_cells [DEPTH];
    logic [TAG_W-1:0] n_cells [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic [TAG_W-1:0] r_popped;
    logic [TAG_W-1:0] n_popped;

    logic             take;
    logic             full;
    logic             empty;
    logic [DEPTH-1:0] match;
    logic [DEPTH-1:0] low_incl;
    logic [DEPTH-1:0] first;
    logic [DEPTH-1:0] rm_mask;

    assign o_cmd_ready = !r_out_valid || i_ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);

    // Compare every live cell against the tag at once
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (r_cells[i] == i_cmd.tag) && (CNT_W'(i) < r_count);
        end
    end

    // Isolate the match nearest the head; cells from there on move up
    assign first    = match & (~match + DEPTH'(1));
    assign low_incl = match ^ (match - DEPTH'(1));
    assign rm_mask  = (i_cmd.op == OP_POP) ? '1 : (~low_incl | first);

    always_comb begin
        n_cells  = r_cells;
        n_count  = r_count;
        n_status = ST_OK;
        n_popped = '0;
        unique case (i_cmd.op)
            OP_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == r_count) begin
                            n_cells[i] = i_cmd.tag;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cells[0] = i_cmd.tag;
                    for (int i = 1; i < DEPTH; i++) begin
                        n_cells[i] = r_cells[i-1];
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_popped = r_cells[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_cells[i] = r_cells[i+1];
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (match == '0) begin
                    n_status = ST_NOMATCH;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (rm_mask[i]) begin
                            n_cells[i] = r_cells[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_NOMATCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cells  <= n_cells;
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Count only changes when a new result is loaded, so it tracks the result
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_popped_item = 32'(r_popped);
    assign o_count       = r_count;

endmodule

### sv/ordered_queue_with_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_queue_with_delete_core
// Ordered tag queue (deque) with append, push, pop and delete-first-match.
// ----------------------------------------------------------------------------
// Holds up to 16 tags in order and executes one command per transaction:
// append at tail, push at head, pop head, or delete the match nearest the
// head, with later tags closing the gap. Every command returns a status, the
// popped tag (zero unless a pop succeeded) and the count after the command.
// Sustained rate is one command per clock while the output is not stalled,
// set by the cell row, which compares and shifts all cells in parallel. A
// command passes from the two-entry command queue, where the cell row works
// out its effect, into the result register that drives the output. A stalled
// output holds the cell row, and the queue then drops o_ready once it holds
// two commands. After reset the block accepts commands at once; no clearing
// pass is run.
module ordered_queue_with_delete_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [31:0]               i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [31:0]               o_popped_item,
    output logic [oqd_pkg::CNT_W-1:0] o_count
);
    import oqd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    oqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    oqd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_popped_item (o_popped_item),
        .o_count       (o_count)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered tag queue with delete.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty and full cases,
// duplicate tags and delete misses. Random phases then follow that lean
// toward filling, draining, mixed traffic or deletes. Each accepted command
// runs through a queue-based model of the cell row, and each returned
// transaction is checked in order against its expected status, popped tag
// and count, from the table for typed rows and else from the model. The
// sender idles in random bursts and the receiver stalls in random modes.
// ----------------------------------------------------------------------------
module testbench;
    import oqd_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] popped;
        logic [CNT_W-1:0] count;
    } t_queue_result;

    typedef struct {
        logic [1:0]       act;
        logic [TAG_W-1:0] tag;
        bit               typed;
        t_queue_result    res;
    } t_stim_row;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED,
        PHASE_DELETE
    } t_phase_kind;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [1:0]       i_action = ACT_APPEND;
    logic [31:0]      i_item   = '0;
    logic             o_valid;
    logic             i_ready  = 1'b0;
    logic [1:0]       o_status;
    logic [31:0]      o_popped_item;
    logic [CNT_W-1:0] o_count;

    logic [TAG_W-1:0] tag_store[$];
    t_queue_result    pending_results[$];
    int               mismatches = 0;
    int               burst_left = 0;
    int               ready_mode = 0;
    int               ready_hold = 0;

    logic [TAG_W-1:0] tag_pool[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                      32'h8000_0001, 32'h1234_5678};

    ordered_queue_with_delete_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_item        (i_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_popped_item (o_popped_item),
        .o_count       (o_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one command to the tag model and return the result it produces.
    function automatic t_queue_result predict_command(input logic [1:0] act,
                                                      input logic [TAG_W-1:0] tag);
        t_queue_result res;
        bit            found;
        res   = '0;
        found = 1'b0;
        res.status = ST_OK;
        case (act)
            ACT_APPEND: begin
                if (tag_store.size() >= DEPTH) res.status = ST_FULL;
                else tag_store.push_back(tag);
            end
            ACT_PUSH: begin
                if (tag_store.size() >= DEPTH) res.status = ST_FULL;
                else tag_store.push_front(tag);
            end
            ACT_POP: begin
                if (tag_store.size() == 0) res.status = ST_EMPTY;
                else res.popped = tag_store.pop_front();
            end
            default: begin
                // remove only the match nearest the head
                for (int i = 0; i < tag_store.size(); i++) begin
                    if (!found && tag_store[i] == tag) begin
                        tag_store.delete(i);
                        found = 1'b1;
                    end
                end
                res.status = found ? ST_OK : ST_NOMATCH;
            end
        endcase
        res.count = CNT_W'(tag_store.size());
        return res;
    endfunction

    function automatic logic [1:0] choose_action(input t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            PHASE_FILL:   return r < 40 ? ACT_APPEND : r < 80 ? ACT_PUSH :
                                 r < 90 ? ACT_POP : ACT_DELETE;
            PHASE_DRAIN:  return r < 10 ? ACT_APPEND : r < 20 ? ACT_PUSH :
                                 r < 60 ? ACT_POP : ACT_DELETE;
            PHASE_MIXED:  return r < 25 ? ACT_APPEND : r < 50 ? ACT_PUSH :
                                 r < 75 ? ACT_POP : ACT_DELETE;
            default:      return r < 30 ? ACT_APPEND : r < 45 ? ACT_PUSH :
                                 r < 55 ? ACT_POP : ACT_DELETE;
        endcase
    endfunction

    // Favor tags already stored for deletes, and a small pool for duplicates.
    function automatic logic [TAG_W-1:0] pick_tag(input logic [1:0] act);
        if (act == ACT_DELETE && tag_store.size() > 0 && $urandom_range(0, 99) < 65)
            return tag_store[$urandom_range(0, tag_store.size() - 1)];
        if ($urandom_range(0, 99) < 35)
            return tag_pool[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    // Drive one command, hold it until accepted, then record its result.
    task automatic send_command(input logic [1:0] act, input logic [TAG_W-1:0] tag,
                                input bit typed, input t_queue_result typed_res);
        t_queue_result predicted;
        int            gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_item   <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        predicted = predict_command(act, tag);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Hold off the sender until every outstanding result has returned.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Receiver stall pattern: always ready, coin flip, sparse, or a hard stall.
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = (ready_mode == 3) ? $urandom_range(1, 30) : $urandom_range(5, 60);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= $urandom_range(0, 1);
            2:       i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d popped=%h count=%0d",
                             o_status, o_popped_item, o_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_popped_item !== want.popped ||
                    o_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp st=%0d pop=%h cnt=%0d, got st=%0d pop=%h cnt=%0d",
                                 want.status, want.popped, want.count,
                                 o_status, o_popped_item, o_count);
                end
            end
        end
    end

    initial begin
        t_stim_row   directed_rows[25];
        t_phase_kind kind;
        logic [1:0]  act;

        directed_rows = '{
            '{ACT_POP,    32'h0000_0000, 1'b1, '{ST_EMPTY,   32'h0, 5'd0}},
            '{ACT_DELETE, 32'h0000_0000, 1'b1, '{ST_NOMATCH, 32'h0, 5'd0}},
            '{ACT_APPEND, 32'h0000_0000, 1'b1, '{ST_OK,      32'h0, 5'd1}},
            '{ACT_PUSH,   32'hFFFF_FFFF, 1'b1, '{ST_OK,      32'h0, 5'd2}},
            '{ACT_APPEND, 32'h5555_5555, 1'b0, '0},
            '{ACT_APPEND, 32'hAAAA_AAAA, 1'b0, '0},
            '{ACT_PUSH,   32'h5555_5555, 1'b0, '0},  // duplicate ahead of the first
            '{ACT_DELETE, 32'h5555_5555, 1'b0, '0},
            '{ACT_DELETE, 32'h1234_5678, 1'b0, '0},
            '{ACT_POP,    32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 5'd3}},
            '{ACT_APPEND, 32'h0000_0001, 1'b0, '0},
            '{ACT_PUSH,   32'h8000_0000, 1'b0, '0},
            '{ACT_APPEND, 32'h7FFF_FFFF, 1'b0, '0},
            '{ACT_PUSH,   32'hFFFF_FFFE, 1'b0, '0},
            '{ACT_APPEND, 32'hDEAD_BEEF, 1'b0, '0},
            '{ACT_PUSH,   32'h0F0F_0F0F, 1'b0, '0},
            '{ACT_APPEND, 32'hF0F0_F0F0, 1'b0, '0},
            '{ACT_PUSH,   32'h0000_FFFF, 1'b0, '0},
            '{ACT_APPEND, 32'hFFFF_0000, 1'b0, '0},
            '{ACT_PUSH,   32'h3333_3333, 1'b0, '0},
            '{ACT_APPEND, 32'hCCCC_CCCC, 1'b0, '0},
            '{ACT_PUSH,   32'h0000_0080, 1'b0, '0},
            '{ACT_APPEND, 32'h0100_0000, 1'b0, '0},
            '{ACT_APPEND, 32'h1111_1111, 1'b1, '{ST_FULL, 32'h0, 5'd16}},
            '{ACT_PUSH,   32'h2222_2222, 1'b1, '{ST_FULL, 32'h0, 5'd16}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_command(directed_rows[i].act, directed_rows[i].tag,
                         directed_rows[i].typed, directed_rows[i].res);
        wait_for_results();

        for (int ph = 0; ph < 20; ph++) begin
            kind = t_phase_kind'(ph % 4);
            if (ph == 7 || ph == 15) wait_for_results();
            for (int n = 0; n < 50; n++) begin
                act = choose_action(kind);
                send_command(act, pick_tag(act), 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS ordered_queue_with_delete_core");
        end else begin
            $display("FAIL ordered_queue_with_delete_core");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL ordered_queue_with_delete_core");
        $finish;
    end

endmodule
